### src/lfu_cache_lru_tiebreak_assert.svh
// Assertion macros for the LFU cache.
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// Same-cycle implication.
`define LFUCL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu cache check failed");

// Next-cycle implication.
`define LFUCL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu cache check failed");

`endif

### src/lfucl_pkg.sv
// Package: sizes, entry and scan result types for the LFU cache.
`default_nettype none
package lfucl_pkg;
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;
  localparam int KEY_W      = 32;
  localparam int CAP_RESET  = 16;
  localparam logic CMD_GET  = 1'b0;
  localparam logic CMD_PUT  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [KEY_W-1:0]      data;
    logic [COUNT_BITS-1:0] count;
    logic [IDX_W-1:0]      rank;
  } entry_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      found_idx;
    logic [IDX_W-1:0]      found_rank;
    logic [COUNT_BITS-1:0] found_count;
    logic [KEY_W-1:0]      found_data;
    logic [CNT_W-1:0]      used;
    logic                  vic_found;
    logic [IDX_W-1:0]      vic_idx;
    logic [IDX_W-1:0]      vic_rank;
    logic [COUNT_BITS-1:0] vic_count;
    logic [KEY_W-1:0]      vic_key;
  } scan_res_t;
endpackage
`default_nettype wire

### src/lfucl_if.sv
// Request and response channel interfaces.
`default_nettype none
interface lfucl_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] lookup_key;
  logic signed [31:0] write_value;
  modport source (output valid, cmd, lookup_key, write_value, input ready);
  modport sink (input valid, cmd, lookup_key, write_value, output ready);
endinterface

interface lfucl_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;
  logic               evicted;
  logic signed [31:0] evicted_key;
  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

### src/lfucl_ram.sv
// Entry RAM: one write port, one read port, registered read data.
`default_nettype none
module lfucl_ram (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [lfucl_pkg::IDX_W-1:0] waddr_i,
  input  wire lfucl_pkg::entry_t       wdata_i,
  input  wire logic [lfucl_pkg::IDX_W-1:0] raddr_i,
  output lfucl_pkg::entry_t            rdata_o
);
  import lfucl_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### src/lfucl_scan.sv
// Scan accumulator: key match, occupancy and LFU/LRU victim over streamed entries.
`default_nettype none
module lfucl_scan (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clear_i,
  input  wire logic                        en_i,
  input  wire logic [lfucl_pkg::IDX_W-1:0] idx_i,
  input  wire logic                        ent_valid_i,
  input  wire lfucl_pkg::entry_t           ent_i,
  input  wire logic [31:0]                 key_i,
  output lfucl_pkg::scan_res_t             res_o
);
  import lfucl_pkg::*;

  scan_res_t res_q, res_d;

  always_comb begin
    res_d = res_q;
    if (clear_i) begin
      res_d = '0;
    end else if (en_i && ent_valid_i) begin
      res_d.used = res_q.used + CNT_W'(1);
      if (!res_q.found && ent_i.key == key_i) begin
        res_d.found       = 1'b1;
        res_d.found_idx   = idx_i;
        res_d.found_rank  = ent_i.rank;
        res_d.found_count = ent_i.count;
        res_d.found_data  = ent_i.data;
      end
      if (!res_q.vic_found || ent_i.count < res_q.vic_count ||
          (ent_i.count == res_q.vic_count && ent_i.rank > res_q.vic_rank)) begin
        res_d.vic_found = 1'b1;
        res_d.vic_idx   = idx_i;
        res_d.vic_rank  = ent_i.rank;
        res_d.vic_count = ent_i.count;
        res_d.vic_key   = ent_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
endmodule
`default_nettype wire

### src/lfu_cache_lru_tiebreak.sv
// LFU cache: one request at a time, a scan pass over the entry RAM, then a write-back pass.
// Hits and new-key puts take both passes; a get miss skips the write-back pass. A new
// request is taken only after the last result is loaded into the result register, so
// the request rate is set by the read sweeps through the entry RAM's single read port,
// plus any time the result register waits on the receiver.
// Reset: all entries invalid, capacity 16; RAM contents are left as they are.
`default_nettype none
module lfu_cache_lru_tiebreak (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lfucl_pkg::CAP_W-1:0]   cfg_wdata_i,
  lfucl_req_if.sink                          req_i,
  lfucl_rsp_if.source                        rsp_o
);
  import lfucl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_UPD    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CAP_W-1:0]   cap_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic               cmd_q;
  logic [31:0]        key_q, val_q;
  logic               hit_q, evict_q;
  logic [IDX_W-1:0]   tgt_q, thr_q;
  logic [COUNT_BITS-1:0] tgt_count_q;
  logic [31:0]        rdv_q, evk_q;
  logic               out_vld_q, out_hit_q, out_ev_q;
  logic [31:0]        out_rdv_q, out_evk_q;

  entry_t    rdata, wdata;
  scan_res_t sr;
  logic      ram_we;
  logic [IDX_W-1:0] raddr;

  logic [31:0]        cap_eff;
  logic               hit_c, new_c, evict_c;
  logic [ENTRIES-1:0] vic_oh, valid_after;
  logic [IDX_W-1:0]   free_idx;
  logic               rsp_free;

  assign raddr = cnt_q[IDX_W-1:0];

  lfucl_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rd_idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lfucl_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (state_q == S_IDLE),
    .en_i        (state_q == S_SCAN && rd_vld_q),
    .idx_i       (rd_idx_q),
    .ent_valid_i (valid_q[rd_idx_q]),
    .ent_i       (rdata),
    .key_i       (key_q),
    .res_o       (sr)
  );

  // Decision after the scan
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = 32'd1;
    end else if (32'(cap_q) > 32'(ENTRIES)) begin
      cap_eff = 32'(ENTRIES);
    end else begin
      cap_eff = 32'(cap_q);
    end
    hit_c   = sr.found;
    new_c   = !sr.found && cmd_q == CMD_PUT;
    evict_c = new_c && sr.vic_found && (32'(sr.used) >= cap_eff);
    vic_oh  = '0;
    if (evict_c) begin
      vic_oh[sr.vic_idx] = 1'b1;
    end
    valid_after = valid_q & ~vic_oh;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // Write-back data
  always_comb begin
    wdata = rdata;
    if (rd_idx_q == tgt_q) begin
      wdata.key   = hit_q ? rdata.key : key_q;
      wdata.data  = (hit_q && cmd_q == CMD_GET) ? rdata.data : val_q;
      wdata.count = hit_q ? tgt_count_q : COUNT_BITS'(1);
      wdata.rank  = '0;
    end else if (hit_q) begin
      wdata.rank = rdata.rank + ((rdata.rank < thr_q) ? IDX_W'(1) : IDX_W'(0));
    end else begin
      wdata.rank = rdata.rank - ((evict_q && rdata.rank > thr_q) ? IDX_W'(1) : IDX_W'(0))
                   + IDX_W'(1);
    end
  end

  assign ram_we   = state_q == S_UPD && rd_vld_q && valid_q[rd_idx_q];
  assign rsp_free = !out_vld_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (req_i.valid) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == CNT_W'(ENTRIES)) begin
          state_d = S_DECIDE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_DECIDE: begin
        valid_d = valid_after;
        if (new_c) begin
          valid_d[free_idx] = 1'b1;
        end
        state_d = (hit_c || new_c) ? S_UPD : S_DONE;
      end
      S_UPD: begin
        if (cnt_q == CNT_W'(ENTRIES)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      valid_q   <= '0;
      cap_q     <= CAP_W'(CAP_RESET);
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= (state_q == S_SCAN || state_q == S_UPD) && cnt_q < CNT_W'(ENTRIES);
      valid_q  <= valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && rsp_free) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= raddr;
    if (state_q == S_IDLE && req_i.valid) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.lookup_key;
      val_q <= req_i.write_value;
    end
    if (state_q == S_DECIDE) begin
      hit_q       <= hit_c;
      evict_q     <= evict_c;
      tgt_q       <= hit_c ? sr.found_idx : free_idx;
      thr_q       <= hit_c ? sr.found_rank : sr.vic_rank;
      tgt_count_q <= (sr.found_count == '1) ? sr.found_count
                                            : sr.found_count + COUNT_BITS'(1);
      rdv_q       <= (hit_c && cmd_q == CMD_GET) ? sr.found_data : '0;
      evk_q       <= evict_c ? sr.vic_key : '0;
    end
    if (state_q == S_DONE && rsp_free) begin
      out_hit_q <= hit_q && (state_q == S_DONE);
      out_rdv_q <= rdv_q;
      out_ev_q  <= evict_q;
      out_evk_q <= evk_q;
    end
  end

  assign req_i.ready       = state_q == S_IDLE;
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.read_value  = out_rdv_q;
  assign rsp_o.evicted     = out_ev_q;
  assign rsp_o.evicted_key = out_evk_q;

  `include "lfu_cache_lru_tiebreak_assert.svh"

  `LFUCL_ASSERT_IMP(a_evict_not_hit, clk_i, rst_ni, rsp_o.valid && rsp_o.evicted, !rsp_o.hit)
  `LFUCL_ASSERT_IMP(a_data_needs_hit, clk_i, rst_ni, rsp_o.valid && rsp_o.read_value != 0, rsp_o.hit)
  `LFUCL_ASSERT_NXT(a_fill_grows, clk_i, rst_ni, state_q == S_DECIDE && new_c && !evict_c, $countones(valid_q) == $past($countones(valid_q)) + 1)
  `LFUCL_ASSERT_NXT(a_evict_keeps, clk_i, rst_ni, state_q == S_DECIDE && evict_c, $countones(valid_q) == $past($countones(valid_q)))
endmodule
`default_nettype wire

### test/lfucl_test_if.sv
// Request and response item types for the testbench.
`timescale 1ns / 100ps
`default_nettype none
package lfucl_test_pkg;
  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } response_t;
endpackage
`default_nettype wire

### test/lfu_cache_lru_tiebreak_test.sv
// Testbench for lfu_cache_lru_tiebreak: directed and random get/put traffic checked against a cache model.
`timescale 1ns / 100ps
`default_nettype none
module lfu_cache_lru_tiebreak_test;
  import lfucl_pkg::*;
  import lfucl_test_pkg::*;

  localparam int CNT_MAX = (1 << COUNT_BITS) - 1;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;

  lfucl_req_if req_ch ();
  lfucl_rsp_if rsp_ch ();

  lfu_cache_lru_tiebreak u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_ch.sink),
    .rsp_o      (rsp_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Cache model state
  bit          slot_valid [ENTRIES];
  bit [31:0]   slot_key   [ENTRIES];
  bit [31:0]   slot_data  [ENTRIES];
  int unsigned slot_count [ENTRIES];
  int unsigned slot_rank  [ENTRIES];
  int unsigned capacity;

  request_t  pending_reqs[$];
  response_t expected_rsps[$];
  int  mismatches = 0;
  bit  failed = 1'b0;
  longint cycles = 0;
  bit  gen_done = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  bit  sender_hold = 1'b0;
  int  hold_off = 0;
  bit  stall_mode = 1'b0;
  int  stall_phase = 0;
  bit  req_taken = 1'b0;

  function automatic void touch(int s);
    if (slot_count[s] < CNT_MAX) slot_count[s]++;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic response_t cache_lookup(request_t rq);
    response_t   r;
    int unsigned cap, used;
    int          found, victim, slot;
    r = '0;
    cap = capacity;
    used = 0;
    found = -1;
    victim = -1;
    slot = -1;
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i]) begin
        used++;
        if (found < 0 && slot_key[i] == rq.key) found = i;
      end
    if (found >= 0) begin
      r.hit = 1'b1;
      touch(found);
      if (rq.cmd == CMD_GET) r.read_value = slot_data[found];
      else slot_data[found] = rq.value;
    end else if (rq.cmd == CMD_PUT) begin
      if (used >= cap) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_valid[i]) continue;
          if (victim < 0 || slot_count[i] < slot_count[victim] ||
              (slot_count[i] == slot_count[victim] && slot_rank[i] > slot_rank[victim]))
            victim = i;
        end
        if (victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[victim];
          slot_valid[victim] = 1'b0;
          for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_rank[i] > slot_rank[victim]) slot_rank[i]--;
        end
      end
      for (int i = 0; i < ENTRIES; i++)
        if (!slot_valid[i]) begin
          slot = i;
          break;
        end
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_valid[i]) slot_rank[i]++;
        slot_valid[slot] = 1'b1;
        slot_key[slot] = rq.key;
        slot_data[slot] = rq.value;
        slot_count[slot] = 1;
        slot_rank[slot] = 0;
      end
    end
    return r;
  endfunction

  // Request transfers are seen at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      expected_rsps.push_back(cache_lookup(pending_reqs.pop_front()));
      req_taken = 1'b1;
    end
  end

  // Driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && !req_taken) begin
        // hold the offered item
      end else if (pending_reqs.size() > 0 && !sender_hold &&
                   (burst_left > 0 || gap_left == 0)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.cmd <= pending_reqs[0].cmd;
        req_ch.lookup_key <= pending_reqs[0].key;
        req_ch.write_value <= pending_reqs[0].value;
      end else begin
        if (gap_left > 0) gap_left--;
        req_ch.valid <= 1'b0;
      end
      req_taken = 1'b0;
    end
  end

  // Response ready pattern
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      rsp_ch.ready <= 1'b0;
    end else begin
      stall_phase++;
      if (stall_phase > 200) begin
        stall_phase = 0;
        stall_mode = !stall_mode;
      end
      rsp_ch.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("lfu_cache_lru_tiebreak_test: FAIL");
        $finish;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected response transfer");
        end else begin
          response_t e;
          e = expected_rsps.pop_front();
          if (rsp_ch.hit !== e.hit || rsp_ch.read_value !== e.read_value ||
              rsp_ch.evicted !== e.evicted || rsp_ch.evicted_key !== e.evicted_key) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit=%0b rd=%h ev=%0b evk=%h got hit=%0b rd=%h ev=%0b evk=%h",
                       e.hit, e.read_value, e.evicted, e.evicted_key, rsp_ch.hit,
                       rsp_ch.read_value, rsp_ch.evicted, rsp_ch.evicted_key);
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_capacity(int unsigned cap);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap[CAP_W-1:0];
    capacity = cap & 5'h1f;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic bit [31:0] pick_key(int unsigned pool);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fff0} + $urandom_range(0, 15);
      default: return 32'h100 + $urandom_range(0, pool);
    endcase
  endfunction

  task automatic add_req(bit c, bit [31:0] k, bit [31:0] v);
    request_t rq;
    rq.cmd = c;
    rq.key = k;
    rq.value = v;
    pending_reqs.push_back(rq);
  endtask

  initial begin
    int unsigned caps [8];
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_GET;
    req_ch.lookup_key = '0;
    req_ch.write_value = '0;
    rsp_ch.ready = 1'b0;
    capacity = CAP_RESET;
    for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty miss, extremes, hits, saturation-free eviction ties
    add_req(CMD_GET, 32'h0, 32'h0);
    add_req(CMD_PUT, 32'h8000_0000, 32'hffff_ffff);
    add_req(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
    add_req(CMD_PUT, 32'hffff_ffff, 32'h7fff_ffff);
    add_req(CMD_PUT, 32'h0, 32'h0);
    add_req(CMD_GET, 32'h8000_0000, 32'h1234_5678);
    add_req(CMD_PUT, 32'h7fff_ffff, 32'h5555_aaaa);
    add_req(CMD_GET, 32'h7fff_ffff, 32'h0);
    add_req(CMD_GET, 32'h1, 32'h0);
    for (int i = 0; i < 14; i++) add_req(CMD_PUT, 32'h40 + i, $urandom());
    drain();
    set_capacity(0);
    add_req(CMD_PUT, 32'h5, 32'h5);
    add_req(CMD_PUT, 32'h6, 32'h6);
    add_req(CMD_GET, 32'h6, 32'h0);
    set_capacity(31);
    for (int i = 0; i < 18; i++) add_req(CMD_PUT, 32'h90 + i, $urandom());
    set_capacity(3);
    for (int i = 0; i < 4; i++) add_req(CMD_PUT, 32'hA0 + i, $urandom());

    // Long receiver hold-off while the sender keeps offering
    drain();
    for (int i = 0; i < 20; i++) add_req($urandom_range(0, 1), pick_key(8), $urandom());
    hold_off = 400;
    drain();

    caps = '{1, 2, 16, 5, 8, 3, 24, 12};
    foreach (caps[p]) begin
      int unsigned pool;
      set_capacity(caps[p]);
      pool = caps[p] + $urandom_range(1, 10);
      for (int n = 0; n < 110; n++) begin
        bit [31:0] k;
        k = pick_key(pool);
        add_req($urandom_range(0, 2) != 0 ? CMD_GET : CMD_PUT, k, $urandom());
        if ($urandom_range(0, 4) == 0) add_req(CMD_GET, k, 32'h0);
      end
      if (p == 3) begin
        drain();
        sender_hold = 1'b0;
      end
    end
    drain();
    if (!failed) begin
      $display("lfu_cache_lru_tiebreak_test: PASS");
    end else begin
      $display("lfu_cache_lru_tiebreak_test: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
